// File: sv/hspc_pkg.sv
// Shared constants, types and Hall sequence tables for the position counter.
package hspc_pkg;

    localparam int COUNT_BITS = 32;
    localparam int NUM_WHEELS = 2;
    localparam int CODE_BITS  = 3;
    localparam int OUT_BITS   = 32;

    typedef logic [CODE_BITS-1:0]  t_code;
    typedef logic [COUNT_BITS-1:0] t_count;
    typedef logic [OUT_BITS-1:0]   t_out_count;

    typedef struct packed {
        t_count count;
        logic   fault;
    } t_lane_stat;

    localparam t_code CODE_NONE_LO = 3'd0;
    localparam t_code CODE_NONE_HI = 3'd7;

    function automatic logic code_valid(input t_code code);
        return (code != CODE_NONE_LO) && (code != CODE_NONE_HI);
    endfunction

    // Predecessor in the sequence 5,1,3,2,6,4 (wrapping).
    function automatic t_code seq_pred(input t_code code);
        t_code r;
        case (code)
            3'd5:    r = 3'd4;
            3'd1:    r = 3'd5;
            3'd3:    r = 3'd1;
            3'd2:    r = 3'd3;
            3'd6:    r = 3'd2;
            3'd4:    r = 3'd6;
            default: r = CODE_NONE_LO;
        endcase
        return r;
    endfunction

    // Successor in the sequence 5,1,3,2,6,4 (wrapping).
    function automatic t_code seq_succ(input t_code code);
        t_code r;
        case (code)
            3'd5:    r = 3'd1;
            3'd1:    r = 3'd3;
            3'd3:    r = 3'd2;
            3'd2:    r = 3'd6;
            3'd6:    r = 3'd4;
            3'd4:    r = 3'd5;
            default: r = CODE_NONE_LO;
        endcase
        return r;
    endfunction

    function automatic t_out_count to_out_count(input t_count c);
        logic [63:0] wide;
        wide = 64'(c);
        return wide[OUT_BITS-1:0];
    endfunction

endpackage

// File: sv/hspc_lane.sv
// One wheel decoder lane: previous code, arm flag, step counter and sticky fault.
module hspc_lane (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_take,
    input  hspc_pkg::t_code     i_code,
    output hspc_pkg::t_lane_stat o_stat
);
    import hspc_pkg::*;

    t_code  r_prev,    n_prev;
    t_count r_count,   n_count;
    logic   r_fault,   n_fault;
    logic   r_unarmed, n_unarmed;

    always_comb begin
        n_prev    = i_code;
        n_count   = r_count;
        n_fault   = r_fault;
        n_unarmed = r_unarmed;
        if (code_valid(i_code)) begin
            if (r_unarmed) begin
                n_unarmed = 1'b0;
            end else if (i_code != r_prev) begin
                if (r_prev == seq_pred(i_code)) begin
                    n_count = r_count + t_count'(1);
                end else if (r_prev == seq_succ(i_code)) begin
                    n_count = r_count - t_count'(1);
                end else begin
                    n_fault = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev    <= '0;
            r_count   <= '0;
            r_fault   <= 1'b0;
            r_unarmed <= 1'b1;
        end else if (i_take) begin
            r_prev    <= n_prev;
            r_count   <= n_count;
            r_fault   <= n_fault;
            r_unarmed <= n_unarmed;
        end
    end

    assign o_stat.count = r_count;
    assign o_stat.fault = r_fault;
endmodule

// File: sv/hspc_merge.sv
// Merge stage: result valid flag, input flow control and per-lane output packing.
module hspc_merge (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_in_valid,
    input  logic                                     i_out_stall,
    input  hspc_pkg::t_lane_stat [hspc_pkg::NUM_WHEELS-1:0] i_stat,
    output logic                                     o_take,
    output logic                                     o_in_stall,
    output logic                                     o_out_valid,
    output hspc_pkg::t_out_count [hspc_pkg::NUM_WHEELS-1:0] o_count,
    output logic [hspc_pkg::NUM_WHEELS-1:0]          o_error
);
    import hspc_pkg::*;

    logic r_valid, n_valid;

    assign o_in_stall = r_valid && i_out_stall;
    assign o_take     = i_in_valid && !o_in_stall;

    always_comb begin
        n_valid = r_valid;
        if (o_take) begin
            n_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_out_valid = r_valid;

    // Lane state changes only on a request, so it holds the shown result.
    always_comb begin
        for (int w = 0; w < NUM_WHEELS; w++) begin
            o_count[w] = to_out_count(i_stat[w].count);
            o_error[w] = i_stat[w].fault;
        end
    end
endmodule

// File: sv/hall_sensor_position_counter.sv
// Top level of the two-wheel Hall sensor position counter.
//
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------------
//  input    | i_valid / o_stall  | i_hall_left, i_hall_right
//  output   | o_valid / i_stall  | o_left_count, o_right_count,
//           |                    | o_left_error, o_right_error
//
// One request per cycle while o_stall is low; its result shows in the cycle after acceptance.
// Each wheel lane updates its counter on acceptance.
// Synchronous reset clears counts and errors and disarms both wheels.
// o_stall rises only while a result waits and i_stall is high; a new
// request is taken in the same cycle the waiting result is taken.
module hall_sensor_position_counter (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [2:0]          i_hall_left,
    input  logic [2:0]          i_hall_right,
    output logic                o_valid,
    input  logic                i_stall,
    output logic signed [31:0]  o_left_count,
    output logic signed [31:0]  o_right_count,
    output logic                o_left_error,
    output logic                o_right_error
);
    import hspc_pkg::*;

    t_code      [NUM_WHEELS-1:0] w_code;
    t_lane_stat [NUM_WHEELS-1:0] w_stat;
    t_out_count [NUM_WHEELS-1:0] w_count;
    logic       [NUM_WHEELS-1:0] w_error;
    logic                        w_take;

    assign w_code[0] = i_hall_left;
    assign w_code[1] = i_hall_right;

    for (genvar g = 0; g < NUM_WHEELS; g++) begin : g_lane
        hspc_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_take  (w_take),
            .i_code  (w_code[g]),
            .o_stat  (w_stat[g])
        );
    end

    hspc_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_out_stall (i_stall),
        .i_stat      (w_stat),
        .o_take      (w_take),
        .o_in_stall  (o_stall),
        .o_out_valid (o_valid),
        .o_count     (w_count),
        .o_error     (w_error)
    );

    assign o_left_count  = signed'(w_count[0]);
    assign o_right_count = signed'(w_count[1]);
    assign o_left_error  = w_error[0];
    assign o_right_error = w_error[1];
endmodule

// File: sv/hspc_checker.sv
// Port-level checker for the position counter, bound to the top level.
module hspc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_stall,
    input logic               o_valid,
    input logic               i_stall,
    input logic signed [31:0] o_left_count,
    input logic signed [31:0] o_right_count,
    input logic               o_left_error,
    input logic               o_right_error
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_left_count) && $stable(o_right_count))
        else $error("stalled result changed");

    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a waiting result");

    a_error_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(o_left_error || o_right_error) |->
            (o_left_error || !$past(o_left_error)) && (o_right_error || !$past(o_right_error)))
        else $error("error flag cleared");

    a_left_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |->
            (o_left_count == $past(o_left_count)) ||
            (o_left_count == $past(o_left_count) + 32'sd1) ||
            (o_left_count == $past(o_left_count) - 32'sd1))
        else $error("left count moved by more than one step");

    a_right_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |->
            (o_right_count == $past(o_right_count)) ||
            (o_right_count == $past(o_right_count) + 32'sd1) ||
            (o_right_count == $past(o_right_count) - 32'sd1))
        else $error("right count moved by more than one step");
endmodule

bind hall_sensor_position_counter hspc_checker u_hspc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_left_count  (o_left_count),
    .o_right_count (o_right_count),
    .o_left_error  (o_left_error),
    .o_right_error (o_right_error)
);

// File: tb/sv/hall_position_checker.sv
// Checker: predicts per-wheel Hall step counts and compares every accepted result.
module hall_position_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_valid,
    input  logic               i_req_stall,
    input  hspc_pkg::t_code    i_hall_left,
    input  hspc_pkg::t_code    i_hall_right,
    input  logic               i_res_valid,
    input  logic               i_res_stall,
    input  logic signed [31:0] i_left_count,
    input  logic signed [31:0] i_right_count,
    input  logic               i_left_error,
    input  logic               i_right_error,
    output int                 o_fail_count,
    output int                 o_pending
);
    import hspc_pkg::*;

    localparam int LEFT  = 0;
    localparam int RIGHT = 1;

    typedef struct packed {
        t_out_count left_count;
        t_out_count right_count;
        logic       left_error;
        logic       right_error;
    } t_wheel_report;

    t_code         last_code   [NUM_WHEELS];
    t_count        step_count  [NUM_WHEELS];
    logic          faulted     [NUM_WHEELS];
    logic          waiting_arm [NUM_WHEELS];
    t_wheel_report pending_reports[$];
    t_wheel_report want;
    t_wheel_report got;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic int ring_slot(input t_code code);
        int s;
        case (code)
            3'd5:    s = 0;
            3'd1:    s = 1;
            3'd3:    s = 2;
            3'd2:    s = 3;
            3'd6:    s = 4;
            3'd4:    s = 5;
            default: s = -1;
        endcase
        return s;
    endfunction

    function automatic void clear_wheels();
        for (int w = 0; w < NUM_WHEELS; w++) begin
            last_code[w]   = CODE_NONE_LO;
            step_count[w]  = '0;
            faulted[w]     = 1'b0;
            waiting_arm[w] = 1'b1;
        end
    endfunction

    function automatic void update_wheel(input int w, input t_code code);
        int s;
        int ps;
        s  = ring_slot(code);
        ps = ring_slot(last_code[w]);
        if (s >= 0) begin
            if (waiting_arm[w]) begin
                waiting_arm[w] = 1'b0;
            end else if (code != last_code[w]) begin
                if (ps == (s + 5) % 6) begin
                    step_count[w] = step_count[w] + 1'b1;
                end else if (ps == (s + 1) % 6) begin
                    step_count[w] = step_count[w] - 1'b1;
                end else begin
                    faulted[w] = 1'b1;
                end
            end
        end
        last_code[w] = code;
    endfunction

    task automatic check_field(input string name, input longint exp_val, input longint act_val);
        if (exp_val != act_val) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, act_val);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_wheels();
            pending_reports.delete();
        end else begin
            if (i_res_valid && !i_res_stall) begin
                got = '{i_left_count, i_right_count, i_left_error, i_right_error};
                if (pending_reports.size() == 0) begin
                    $display("%0t: result with no request waiting, actual %0d %0d %0b %0b",
                             $time, i_left_count, i_right_count, i_left_error, i_right_error);
                    o_fail_count++;
                end else begin
                    want = pending_reports.pop_front();
                    check_field("left_count", longint'($signed(want.left_count)),
                                longint'($signed(got.left_count)));
                    check_field("right_count", longint'($signed(want.right_count)),
                                longint'($signed(got.right_count)));
                    check_field("left_error", want.left_error, got.left_error);
                    check_field("right_error", want.right_error, got.right_error);
                end
            end
            if (i_req_valid && !i_req_stall) begin
                update_wheel(LEFT, i_hall_left);
                update_wheel(RIGHT, i_hall_right);
                want.left_count  = step_count[LEFT];
                want.right_count = step_count[RIGHT];
                want.left_error  = faulted[LEFT];
                want.right_error = faulted[RIGHT];
                pending_reports.push_back(want);
            end
        end
        o_pending = pending_reports.size();
    end

endmodule

// File: tb/sv/testbench.sv
// Testbench top: drives Hall samples under handshake pressure and reports the verdict.
module testbench;
    import hspc_pkg::*;

    localparam int RANDOM_PER_PHASE = 425;

    logic               i_clk        = 1'b0;
    logic               i_rst_n      = 1'b0;
    logic               i_valid      = 1'b0;
    logic               o_stall;
    t_code              i_hall_left  = CODE_NONE_LO;
    t_code              i_hall_right = CODE_NONE_LO;
    logic               o_valid;
    logic               i_stall      = 1'b0;
    logic signed [31:0] o_left_count;
    logic signed [31:0] o_right_count;
    logic               o_left_error;
    logic               o_right_error;

    int fail_count;
    int pending;
    int idle_pct  = 0;
    int stall_pct = 0;
    int sent      = 0;
    int left_slot;
    int right_slot;

    hall_sensor_position_counter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_hall_left   (i_hall_left),
        .i_hall_right  (i_hall_right),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_left_count  (o_left_count),
        .o_right_count (o_right_count),
        .o_left_error  (o_left_error),
        .o_right_error (o_right_error)
    );

    hall_position_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (i_valid),
        .i_req_stall   (o_stall),
        .i_hall_left   (i_hall_left),
        .i_hall_right  (i_hall_right),
        .i_res_valid   (o_valid),
        .i_res_stall   (i_stall),
        .i_left_count  (o_left_count),
        .i_right_count (o_right_count),
        .i_left_error  (o_left_error),
        .i_right_error (o_right_error),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("hall_sensor_position_counter verification failed");
        $finish;
    end

    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    function automatic t_code ring_code(input int slot);
        t_code c;
        case (slot)
            0:       c = 3'd5;
            1:       c = 3'd1;
            2:       c = 3'd3;
            3:       c = 3'd2;
            4:       c = 3'd6;
            default: c = 3'd4;
        endcase
        return c;
    endfunction

    // Mostly legal steps with holds, skips and invalid codes mixed in.
    function automatic t_code next_hall(inout int slot);
        int r;
        r = $urandom_range(99);
        if (slot < 0 || r < 5) begin
            slot = $urandom_range(5);
        end else if (r < 45) begin
            slot = (slot + 1) % 6;
        end else if (r < 75) begin
            slot = (slot + 5) % 6;
        end else if (r < 85) begin
            slot = slot;
        end else if (r < 92) begin
            slot = $urandom_range(5);
        end else begin
            slot = -1;
            return $urandom_range(1) ? CODE_NONE_HI : CODE_NONE_LO;
        end
        return ring_code(slot);
    endfunction

    task automatic send_sample(input t_code left, input t_code right);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_hall_left  <= left;
        i_hall_right <= right;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sent++;
        @(negedge i_clk);
    endtask

    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // invalid codes before arming, then arm on codes that follow invalid ones
        send_sample(3'd0, 3'd7);
        send_sample(3'd7, 3'd0);
        send_sample(3'd5, 3'd4);
        send_sample(3'd5, 3'd4);
        // left forward through the wrap, right backward through the wrap, then both reverse
        send_sample(3'd1, 3'd6);
        send_sample(3'd3, 3'd2);
        send_sample(3'd2, 3'd3);
        send_sample(3'd6, 3'd1);
        send_sample(3'd4, 3'd5);
        send_sample(3'd5, 3'd4);
        send_sample(3'd4, 3'd5);
        send_sample(3'd6, 3'd1);
        // left valid code after an invalid one, then keep counting while faulted
        send_sample(3'd7, 3'd3);
        send_sample(3'd1, 3'd2);
        send_sample(3'd3, 3'd2);
        send_sample(3'd3, 3'd3);

        left_slot  = 2;
        right_slot = 2;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 48; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 48; end
                default: begin idle_pct = 18; stall_pct = 18; end
            endcase
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                send_sample(next_hall(left_slot), next_hall(right_slot));
            end
        end

        i_valid   <= 1'b0;
        stall_pct = 0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);

        $display("Drove %0d Hall sample pairs: arming, steps both ways, wraps, holds,", sent);
        $display("skips and invalid codes, under four sender/receiver pressure mixes.");
        if (fail_count == 0) begin
            $display("hall_sensor_position_counter verification clean");
        end else begin
            $display("hall_sensor_position_counter verification failed");
        end
        $finish;
    end

endmodule
